[hw/rtl/bed_genotype_decode_stats_defines.svh]
// Assertion macros shared by the genotype decode checker.
`ifndef BED_GENOTYPE_DECODE_STATS_DEFINES_SVH
`define BED_GENOTYPE_DECODE_STATS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BGDS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BGDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bgds_pkg.sv]
// Shared types, tables and constants for the genotype decode block.
package bgds_pkg;

   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 96;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_ADDR_ALT_FIRST = 2'd0;

   localparam logic [1:0] CODE_MISSING = 2'd1;

   typedef logic signed [2:0] geno_type;

   // code -> alt allele count; missing reads as -1
   localparam geno_type ALT_FIRST_MAP [4] = '{3'sd2, 3'b111, 3'sd1, 3'sd0};
   localparam geno_type REF_FIRST_MAP [4] = '{3'sd0, 3'b111, 3'sd1, 3'sd2};

endpackage

[hw/rtl/bgds_decode.sv]
// Two-bit genotype code extraction and allele-count mapping.
module bgds_decode (
   input  logic                alt_first,
   input  logic [7:0]          packed_byte,
   input  logic [1:0]          slot,
   output bgds_pkg::geno_type  genotype,
   output logic                is_missing
);

   logic [1:0] code;

   assign code       = packed_byte[{slot, 1'b0} +: 2];
   assign genotype   = alt_first ? bgds_pkg::ALT_FIRST_MAP[code]
                                 : bgds_pkg::REF_FIRST_MAP[code];
   assign is_missing = (code == bgds_pkg::CODE_MISSING);

endmodule

[hw/rtl/bgds_divider.sv]
// Restoring divider, one quotient bit a cycle, for (num << FRAC) / den.
module bgds_divider #(
   parameter int W    = 18,
   parameter int FRAC = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   output logic          done,
   output logic [FRAC:0] quot
);

   localparam int SW = $clog2(FRAC + 2);

   // Quotient is known to be below 2^(FRAC+1), so the top of the dividend
   // (num >> 1) already sits below den and only FRAC+1 steps remain.
   logic [W-1:0]  rem_ff,  rem_in;
   logic [W-1:0]  den_ff,  den_in;
   logic          lsb_ff,  lsb_in;
   logic [FRAC:0] quot_ff, quot_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic          bit_in;
   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          take;

   always_comb begin
      bit_in = (step_ff == '0) ? lsb_ff : 1'b0;
      trial  = {rem_ff, bit_in};
      diff   = trial - {1'b0, den_ff};
      take   = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      den_in  = den_ff;
      lsb_in  = lsb_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = num >> 1;
         den_in  = den;
         lsb_in  = num[0];
         quot_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? diff[W-1:0] : trial[W-1:0];
         quot_in = {quot_ff[FRAC-1:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(FRAC)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      lsb_ff  <= lsb_in;
      quot_ff <= quot_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hw/rtl/bed_genotype_decode_stats.sv]
// Genotype decode with per-marker statistics. Each req beat is one sample: a
// packed byte of four 2-bit codes and the slot to use; rsp returns its allele
// count, missing flag and index. A sample that is not the last of its marker
// is answered from the rsp register and a new beat is taken every cycle while
// rsp drains. The last sample of a marker runs two divisions on one shared
// bit-serial divider (missing rate, then alt frequency), and req_tready stays
// low while they run. The alt frequency division is skipped when every
// sample was missing. Counters clear after the last sample. Samples past
// MAX_SAMPLES in one marker are decoded but not counted.
module bed_genotype_decode_stats #(
   parameter int MAX_SAMPLES = bgds_pkg::MAX_SAMPLES_DEF,
   parameter int FRAC_BITS   = bgds_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] packed_byte, [9:8] slot, rest zero
   input  logic [bgds_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] genotype, [3] is_missing, [19:4] sample_index, [37:20] alt_total,
   // [54:38] missing_total, [71:55] missing_rate, [88:72] alt_freq, rest zero
   output logic [bgds_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bgds_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bgds_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bgds_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int AW  = CW + 1;
   localparam int IXW = (CW > 16) ? CW : 16;
   localparam int AXW = (AW > 18) ? AW : 18;
   localparam int MXW = (CW > 17) ? CW : 17;
   localparam int QXW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RATE = 3'b010,
      ST_FREQ = 3'b100
   } state_type;

   state_type         state_ff,     state_in;
   logic              alt_first_ff, alt_first_in;
   logic [CW-1:0]     count_ff,     count_in;
   logic [CW-1:0]     miss_cnt_ff,  miss_cnt_in;
   logic [AW-1:0]     alt_sum_ff,   alt_sum_in;
   logic [AW-1:0]     alt_op_ff,    alt_op_in;
   logic [AW-1:0]     pres2_ff,     pres2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bgds_pkg::geno_type geno_ff,     geno_in;
   logic              miss_ff,      miss_in;
   logic [15:0]       idx_ff,       idx_in;
   logic              last_ff,      last_in;
   logic [17:0]       alt_tot_ff,   alt_tot_in;
   logic [16:0]       miss_tot_ff,  miss_tot_in;
   logic [16:0]       rate_ff,      rate_in;
   logic [16:0]       freq_ff,      freq_in;

   bgds_pkg::geno_type dec_geno;
   logic              dec_miss;
   logic              req_fire;
   logic              has_room;
   logic [CW-1:0]     count_new;
   logic [CW-1:0]     miss_new;
   logic [AW-1:0]     alt_new;
   logic [CW-1:0]     present_new;
   logic [CW-1:0]     idx_raw;
   logic [IXW-1:0]    idx_ext;
   logic [AXW-1:0]    alt_ext;
   logic [MXW-1:0]    miss_ext;
   logic [QXW-1:0]    quot_ext;
   logic              csr_write;

   logic              div_start;
   logic [AW-1:0]     div_num;
   logic [AW-1:0]     div_den;
   logic              div_done;
   logic [FRAC_BITS:0] div_quot;

   bgds_decode u_decode (
      .alt_first   (alt_first_ff),
      .packed_byte (req_tdata[7:0]),
      .slot        (req_tdata[9:8]),
      .genotype    (dec_geno),
      .is_missing  (dec_miss)
   );

   bgds_divider #(
      .W    (AW),
      .FRAC (FRAC_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == bgds_pkg::REG_ADDR_ALT_FIRST);

   always_comb begin
      has_room    = (count_ff < CW'(MAX_SAMPLES));
      count_new   = has_room ? count_ff + 1'b1 : count_ff;
      miss_new    = (has_room && dec_miss) ? miss_cnt_ff + 1'b1 : miss_cnt_ff;
      alt_new     = (has_room && !dec_miss) ? alt_sum_ff + AW'(dec_geno[1:0])
                                            : alt_sum_ff;
      present_new = count_new - miss_new;
      idx_raw     = has_room ? count_ff : CW'(MAX_SAMPLES - 1);
      idx_ext     = IXW'(idx_raw);
      alt_ext     = AXW'(alt_new);
      miss_ext    = MXW'(miss_new);
      quot_ext    = QXW'(div_quot);

      // first division straight from the incoming beat, second from the latch
      if (state_ff == ST_IDLE) begin
         div_num   = AW'(miss_new);
         div_den   = AW'(count_new);
         div_start = req_fire && req_tlast;
      end else begin
         div_num   = alt_op_ff;
         div_den   = pres2_ff;
         div_start = (state_ff == ST_RATE) && div_done && (pres2_ff != '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      alt_first_in = csr_write ? csr_pwdata[0] : alt_first_ff;
      count_in     = count_ff;
      miss_cnt_in  = miss_cnt_ff;
      alt_sum_in   = alt_sum_ff;
      alt_op_in    = alt_op_ff;
      pres2_in     = pres2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      geno_in      = geno_ff;
      miss_in      = miss_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      alt_tot_in   = alt_tot_ff;
      miss_tot_in  = miss_tot_ff;
      rate_in      = rate_ff;
      freq_in      = freq_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               geno_in     = dec_geno;
               miss_in     = dec_miss;
               idx_in      = idx_ext[15:0];
               last_in     = req_tlast;
               rate_in     = '0;
               freq_in     = '0;
               alt_op_in   = alt_new;
               pres2_in    = {present_new, 1'b0};
               if (req_tlast) begin
                  alt_tot_in  = alt_ext[17:0];
                  miss_tot_in = miss_ext[16:0];
                  count_in    = '0;
                  miss_cnt_in = '0;
                  alt_sum_in  = '0;
                  state_in    = ST_RATE;
               end else begin
                  alt_tot_in   = '0;
                  miss_tot_in  = '0;
                  count_in     = count_new;
                  miss_cnt_in  = miss_new;
                  alt_sum_in   = alt_new;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_RATE: begin
            if (div_done) begin
               rate_in = quot_ext[16:0];
               if (pres2_ff == '0) begin
                  // every sample missing: frequency stays zero
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_FREQ;
               end
            end
         end
         ST_FREQ: begin
            if (div_done) begin
               freq_in      = quot_ext[16:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      alt_op_ff   <= alt_op_in;
      pres2_ff    <= pres2_in;
      geno_ff     <= geno_in;
      miss_ff     <= miss_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      alt_tot_ff  <= alt_tot_in;
      miss_tot_ff <= miss_tot_in;
      rate_ff     <= rate_in;
      freq_ff     <= freq_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         alt_first_ff <= 1'b0;
         count_ff     <= '0;
         miss_cnt_ff  <= '0;
         alt_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alt_first_ff <= alt_first_in;
         count_ff     <= count_in;
         miss_cnt_ff  <= miss_cnt_in;
         alt_sum_ff   <= alt_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'b0, freq_ff, rate_ff, miss_tot_ff, alt_tot_ff,
                        idx_ff, miss_ff, geno_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == bgds_pkg::REG_ADDR_ALT_FIRST)
                       ? {{(bgds_pkg::CSR_DATA_W - 1){1'b0}}, alt_first_ff}
                       : '0;

endmodule

[hw/rtl/bgds_checker.sv]
// Port-level checks for the genotype decode block, bound to the top level.
`include "bed_genotype_decode_stats_defines.svh"

module bgds_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bgds_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast
);

   // stalled rsp beat holds
   `BGDS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed while stalled")

   // single output slot: no new sample while a result waits
   `BGDS_ASSERT_NOW(a_no_overrun, rsp_tvalid && !rsp_tready, !req_tready,
      "req taken while rsp slot full")

   // ordinary sample answers on the next cycle
   `BGDS_ASSERT_NEXT(a_fast_path, req_tvalid && req_tready && !req_tlast, rsp_tvalid,
      "no rsp after non-last sample")

   // end of marker: divisions under way, nothing shown or taken
   `BGDS_ASSERT_NEXT(a_div_busy, req_tvalid && req_tready && req_tlast,
      !req_tready && !rsp_tvalid, "block not busy after last sample")

   // totals and rates only on the final beat
   `BGDS_ASSERT_NOW(a_totals_zero, rsp_tvalid && !rsp_tlast, rsp_tdata[88:20] == '0,
      "totals nonzero on non-final beat")

endmodule

bind bed_genotype_decode_stats bgds_checker u_bgds_checker (.*);

[dv/tb.sv]
// Self-checking bench for the genotype decode and per-marker statistics block.
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 2 * bgds_pkg::FRAC_BITS_DEF + 8;

   typedef struct {
      bgds_pkg::geno_type genotype;
      logic               is_missing;
      logic [15:0]        sample_index;
      logic               final_result;
      logic [17:0]        alt_total;
      logic [16:0]        missing_total;
      logic [16:0]        missing_rate;
      logic [16:0]        alt_freq;
   } geno_call_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [bgds_pkg::REQ_TDATA_W-1:0]  req_tdata;
   logic                              req_tlast;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [bgds_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [bgds_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [bgds_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [bgds_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // predictor state
   bit          alt_first_mode;
   int unsigned alt_acc;
   int unsigned miss_acc;
   int unsigned count_acc;

   geno_call_type genotype_calls_due[$];
   int            send_idle_pct;
   int            recv_idle_pct;
   int            mismatches;
   int            stalled_cycles;

   bed_genotype_decode_stats uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // decode one sample and advance the per-marker counters
   function automatic geno_call_type decode_sample(input logic [7:0] pbyte,
                                                   input logic [1:0] slot,
                                                   input logic last);
      geno_call_type   c;
      logic [1:0]      code;
      longint unsigned n, miss, alt, present, rate, freq;
      c = '{default: '0};
      code = pbyte[2*slot +: 2];
      if (code == bgds_pkg::CODE_MISSING) begin
         c.genotype   = bgds_pkg::geno_type'(-1);
         c.is_missing = 1'b1;
      end else if (alt_first_mode) begin
         c.genotype = (code == 2'd0) ? 3'sd2 : (code == 2'd2) ? 3'sd1 : 3'sd0;
      end else begin
         c.genotype = (code == 2'd3) ? 3'sd2 : (code == 2'd2) ? 3'sd1 : 3'sd0;
      end
      if (count_acc < bgds_pkg::MAX_SAMPLES_DEF) begin
         c.sample_index = count_acc[15:0];
         count_acc++;
         if (c.is_missing)
            miss_acc++;
         else
            alt_acc += int'(c.genotype);
      end else begin
         c.sample_index = 16'(bgds_pkg::MAX_SAMPLES_DEF - 1);
      end
      c.final_result = last;
      if (last) begin
         n       = count_acc;
         miss    = miss_acc;
         alt     = alt_acc;
         present = n - miss;
         rate    = (miss << bgds_pkg::FRAC_BITS_DEF) / n;
         freq    = (present > 0) ? (alt << bgds_pkg::FRAC_BITS_DEF) / (2 * present) : 0;
         c.alt_total     = alt[17:0];
         c.missing_total = miss[16:0];
         c.missing_rate  = rate[16:0];
         c.alt_freq      = freq[16:0];
         alt_acc   = 0;
         miss_acc  = 0;
         count_acc = 0;
      end
      return c;
   endfunction

   task automatic push_sample(input logic [7:0] pbyte, input logic [1:0] slot,
                              input logic last);
      geno_call_type call;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bgds_pkg::REQ_TDATA_W'({slot, pbyte});
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      call = decode_sample(pbyte, slot, last);
      genotype_calls_due.insert(genotype_calls_due.size(), call);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (genotype_calls_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_alt_first(input bit mode);
      logic [bgds_pkg::CSR_DATA_W-1:0] wdata;
      wdata      = $urandom();
      wdata[0]   = mode;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bgds_pkg::REG_ADDR_ALT_FIRST;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      alt_first_mode = mode;
   endtask

   // byte 0xE4 holds codes 0,1,2,3 in slots 0..3
   task automatic test_code_tables();
      for (int m = 0; m < 2; m++) begin
         wait_drained();
         write_alt_first(m[0]);
         for (int s = 0; s < 4; s++)
            push_sample(8'hE4, 2'(s), s == 3);
      end
   endtask

   task automatic test_missing_and_single();
      for (int s = 0; s < 3; s++)
         push_sample(8'h55, 2'(s), s == 2);
      push_sample(8'h55, 2'd3, 1'b1);
      push_sample(8'h00, 2'd0, 1'b1);
      push_sample(8'hFF, 2'd3, 1'b1);
      push_sample(8'hAA, 2'd1, 1'b0);
      push_sample(8'h55, 2'd0, 1'b1);
   endtask

   task automatic test_random_markers(input int n_items, input int snd_pct, input int rcv_pct,
                                      input bit mode);
      int         left;
      int         flavor;
      logic [7:0] pbyte;
      wait_drained();
      write_alt_first(mode);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      left = 0;
      for (int i = 0; i < n_items; i++) begin
         if (left == 0) begin
            left   = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 60);
            flavor = $urandom_range(99);
         end
         if (flavor < 70)
            pbyte = 8'($urandom());
         else if (flavor < 85)
            pbyte = 8'h55;
         else
            pbyte = $urandom_range(1) ? 8'h00 : 8'hFF;
         // close the marker at the end of the phase
         push_sample(pbyte, 2'($urandom_range(3)), left == 1 || i == n_items - 1);
         left--;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic check_field(input string name, input longint expv, input longint actv);
      if (expv != actv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      geno_call_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (genotype_calls_due.size() == 0) begin
            $error("unexpected rsp beat: %h", rsp_tdata);
            mismatches++;
         end else begin
            due = genotype_calls_due.pop_front();
            check_field("genotype", longint'(due.genotype), longint'($signed(rsp_tdata[2:0])));
            check_field("is_missing", due.is_missing, rsp_tdata[3]);
            check_field("sample_index", due.sample_index, rsp_tdata[19:4]);
            check_field("final_result", due.final_result, rsp_tlast);
            check_field("alt_total", due.alt_total, rsp_tdata[37:20]);
            check_field("missing_total", due.missing_total, rsp_tdata[54:38]);
            check_field("missing_rate", due.missing_rate, rsp_tdata[71:55]);
            check_field("alt_freq", due.alt_freq, rsp_tdata[88:72]);
         end
      end
   end

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("bed_genotype_decode_stats regression: fail");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      alt_first_mode = 1'b0;
      alt_acc        = 0;
      miss_acc       = 0;
      count_acc      = 0;
      mismatches     = 0;
      stalled_cycles = 0;
      send_idle_pct  = 34;
      recv_idle_pct  = 61;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_code_tables();
      test_missing_and_single();
      test_random_markers(211, 34, 61, 1'b1);
      test_random_markers(211, 61, 34, 1'b0);
      test_random_markers(211, 0, 0, 1'b1);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && genotype_calls_due.size() == 0)
         $display("bed_genotype_decode_stats regression: pass");
      else
         $display("bed_genotype_decode_stats regression: fail");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bgds_pkg.sv
hw/rtl/bgds_decode.sv
hw/rtl/bgds_divider.sv
hw/rtl/bed_genotype_decode_stats.sv
hw/rtl/bgds_checker.sv
dv/tb.sv
